// File: rtl/ttg_pkg.sv
// ttg_pkg: widths, job record and sequencer states for the triangle tangent generator.
// Depends on nothing; every other rtl file refers to it by scoped names.
package ttg_pkg;

	localparam int POS_W     = 32;
	localparam int TEX_W     = 16;
	localparam int TAN_W     = 16;
	localparam int DIFF_DROP = (POS_W > 35) ? POS_W - 35 : 0;
	localparam int E_W       = POS_W + 1 - DIFF_DROP;
	localparam int UVD_W     = TEX_W + 1;
	localparam int MAG_W     = E_W + UVD_W;
	localparam int T_W       = MAG_W + 1;
	localparam int NORM_BITS = 30;
	localparam int NV_W      = (MAG_W > NORM_BITS) ? MAG_W : NORM_BITS;
	localparam int CNT_W     = $clog2(NV_W + 1);
	localparam int SQ_W      = 2 * NORM_BITS + 2;
	localparam int RT_W      = NORM_BITS + 1;
	localparam int R_W       = RT_W + 1;
	localparam int UNIT_FRAC = TAN_W - 2;
	localparam int Q_W       = UNIT_FRAC + 1;
	localparam int N_W       = NORM_BITS + UNIT_FRAC + 1;
	localparam int DC_W      = $clog2(Q_W + 1);
	localparam int QDEPTH    = 2;
	localparam int QA_W      = $clog2(QDEPTH);
	localparam int QC_W      = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic signed [E_W-1:0]   e10x;
		logic signed [E_W-1:0]   e10y;
		logic signed [E_W-1:0]   e10z;
		logic signed [E_W-1:0]   e20x;
		logic signed [E_W-1:0]   e20y;
		logic signed [E_W-1:0]   e20z;
		logic signed [UVD_W-1:0] d10u;
		logic signed [UVD_W-1:0] d10v;
		logic signed [UVD_W-1:0] d20u;
		logic signed [UVD_W-1:0] d20v;
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} q_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DET,
		ST_TAN,
		ST_LZ,
		ST_SHIFT,
		ST_SQ,
		ST_SQRT,
		ST_DINIT,
		ST_DIV,
		ST_OUT
	} bk_state_t;

	// edge difference, floor-shifted to E_W bits
	function automatic logic signed [E_W-1:0] diff_e(input logic signed [POS_W-1:0] a,
			input logic signed [POS_W-1:0] b);
		logic signed [POS_W:0] d;
		d = (POS_W + 1)'(a) - (POS_W + 1)'(b);
		return E_W'(d >>> DIFF_DROP);
	endfunction

	function automatic logic signed [UVD_W-1:0] diff_uv(input logic signed [TEX_W-1:0] a,
			input logic signed [TEX_W-1:0] b);
		return UVD_W'(a) - UVD_W'(b);
	endfunction

endpackage

// File: rtl/ttg_if.sv
// ttg_if: vertex and tangent channel interfaces (valid/ready plus payload).
// Depends on ttg_pkg for field widths.
interface ttg_vtx_if;
	logic                             valid;
	logic                             ready;
	logic signed [ttg_pkg::POS_W-1:0] pos_x;
	logic signed [ttg_pkg::POS_W-1:0] pos_y;
	logic signed [ttg_pkg::POS_W-1:0] pos_z;
	logic signed [ttg_pkg::TEX_W-1:0] tex_u;
	logic signed [ttg_pkg::TEX_W-1:0] tex_v;
	logic                             last_in_mesh;
	modport source(output valid, pos_x, pos_y, pos_z, tex_u, tex_v, last_in_mesh, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, tex_u, tex_v, last_in_mesh, output ready);
endinterface

interface ttg_tan_if;
	logic                             valid;
	logic                             ready;
	logic signed [ttg_pkg::TAN_W-1:0] tan_x;
	logic signed [ttg_pkg::TAN_W-1:0] tan_y;
	logic signed [ttg_pkg::TAN_W-1:0] tan_z;
	logic                             degenerate;
	logic                             last_of_triangle;
	modport source(output valid, tan_x, tan_y, tan_z, degenerate, last_of_triangle, input ready);
	modport sink(input valid, tan_x, tan_y, tan_z, degenerate, last_of_triangle, output ready);
endinterface

// File: rtl/ttg_front.sv
// ttg_front: vertex intake, corner holding, edge/UV differences on the third corner.
// Depends on ttg_pkg and ttg_vtx_if.
module ttg_front (
	input  logic               clk,
	input  logic               arst_n,
	ttg_vtx_if.sink            vtx,
	input  ttg_pkg::q_stat_t   qstat,
	output ttg_pkg::q_push_t   qpush
);

	logic [1:0]                       count_q;
	logic signed [ttg_pkg::POS_W-1:0] hpx_q [2];
	logic signed [ttg_pkg::POS_W-1:0] hpy_q [2];
	logic signed [ttg_pkg::POS_W-1:0] hpz_q [2];
	logic signed [ttg_pkg::TEX_W-1:0] hu_q [2];
	logic signed [ttg_pkg::TEX_W-1:0] hv_q [2];
	logic                             third;
	logic                             acc;

	assign third     = (count_q == 2'd2);
	assign vtx.ready = !third || !qstat.full;
	assign acc       = vtx.valid && vtx.ready;

	always_comb begin
		qpush.push     = acc && third;
		qpush.job.e10x = ttg_pkg::diff_e(hpx_q[1], hpx_q[0]);
		qpush.job.e10y = ttg_pkg::diff_e(hpy_q[1], hpy_q[0]);
		qpush.job.e10z = ttg_pkg::diff_e(hpz_q[1], hpz_q[0]);
		qpush.job.e20x = ttg_pkg::diff_e(vtx.pos_x, hpx_q[0]);
		qpush.job.e20y = ttg_pkg::diff_e(vtx.pos_y, hpy_q[0]);
		qpush.job.e20z = ttg_pkg::diff_e(vtx.pos_z, hpz_q[0]);
		qpush.job.d10u = ttg_pkg::diff_uv(hu_q[1], hu_q[0]);
		qpush.job.d10v = ttg_pkg::diff_uv(hv_q[1], hv_q[0]);
		qpush.job.d20u = ttg_pkg::diff_uv(vtx.tex_u, hu_q[0]);
		qpush.job.d20v = ttg_pkg::diff_uv(vtx.tex_v, hv_q[0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else if (acc) begin
			if (vtx.last_in_mesh || third) begin
				count_q <= 2'd0;
			end else begin
				count_q <= count_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !third) begin
			hpx_q[count_q[0]] <= vtx.pos_x;
			hpy_q[count_q[0]] <= vtx.pos_y;
			hpz_q[count_q[0]] <= vtx.pos_z;
			hu_q[count_q[0]]  <= vtx.tex_u;
			hv_q[count_q[0]]  <= vtx.tex_v;
		end
	end

endmodule

// File: rtl/ttg_fifo.sv
// ttg_fifo: short job queue between front and back.
// Depends on ttg_pkg.
module ttg_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  ttg_pkg::q_push_t qpush,
	input  logic             pop,
	output ttg_pkg::q_stat_t qstat,
	output ttg_pkg::job_t    head
);

	ttg_pkg::job_t                mem_q [ttg_pkg::QDEPTH];
	logic [ttg_pkg::QA_W-1:0]     wp_q;
	logic [ttg_pkg::QA_W-1:0]     rp_q;
	logic [ttg_pkg::QC_W-1:0]     cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign qstat.full  = (cnt_q == ttg_pkg::QC_W'(ttg_pkg::QDEPTH));
	assign qstat.empty = (cnt_q == '0);
	assign do_push     = qpush.push && !qstat.full;
	assign do_pop      = pop && !qstat.empty;
	assign head        = mem_q[rp_q];

	// depth is a power of two, pointers wrap on their own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= wp_q + 1'b1;
			end
			if (do_pop) begin
				rp_q <= rp_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wp_q] <= qpush.job;
		end
	end

endmodule

// File: rtl/ttg_back.sv
// ttg_back: tangent sequencer - products, normalize, square root, divides, three result beats.
// Depends on ttg_pkg and ttg_tan_if.
module ttg_back (
	input  logic             clk,
	input  logic             arst_n,
	input  ttg_pkg::q_stat_t qstat,
	input  ttg_pkg::job_t    head,
	output logic             pop,
	ttg_tan_if.source        tan
);

	ttg_pkg::bk_state_t state_q, state_d;
	ttg_pkg::job_t      job_q;

	logic                                 flip_q;
	logic                                 degen_q;
	logic [1:0]                           k_q;
	logic [1:0]                           beat_q;
	logic [ttg_pkg::MAG_W-1:0]            mag_q [3];
	logic                                 neg_q [3];
	logic [ttg_pkg::MAG_W-1:0]            or_q;
	logic [ttg_pkg::NV_W-1:0]             nv_q;
	logic [ttg_pkg::CNT_W-1:0]            cnt_q;
	logic [ttg_pkg::NORM_BITS-1:0]        m_q [3];
	logic [ttg_pkg::SQ_W-1:0]             sq_q;
	logic [ttg_pkg::SQ_W-1:0]             x_q;
	logic [ttg_pkg::SQ_W-1:0]             r_q;
	logic [ttg_pkg::SQ_W-1:0]             bit_q;
	logic [ttg_pkg::R_W-1:0]              rem_q;
	logic [ttg_pkg::Q_W-1:0]              nlo_q;
	logic [ttg_pkg::Q_W-1:0]              q_q;
	logic [ttg_pkg::DC_W-1:0]             dcnt_q;
	logic signed [ttg_pkg::TAN_W-1:0]     comp_q [3];

	logic signed [ttg_pkg::E_W-1:0]       e10_sel;
	logic signed [ttg_pkg::E_W-1:0]       e20_sel;
	logic signed [ttg_pkg::MAG_W-1:0]     pa, pb;
	logic signed [ttg_pkg::T_W-1:0]       t_raw, t_dir;
	logic [ttg_pkg::MAG_W-1:0]            t_abs;
	logic signed [2*ttg_pkg::UVD_W-1:0]   da, db;
	logic signed [2*ttg_pkg::UVD_W:0]     det;
	logic [ttg_pkg::NV_W-1:0]             sh;
	logic [2*ttg_pkg::NORM_BITS-1:0]      sqp;
	logic [ttg_pkg::SQ_W:0]               trial;
	logic [ttg_pkg::RT_W-1:0]             len;
	logic [ttg_pkg::N_W-1:0]              num;
	logic [ttg_pkg::R_W-1:0]              rem2;
	logic                                 ge;
	logic [ttg_pkg::Q_W-1:0]              q_fin;
	logic signed [ttg_pkg::TAN_W-1:0]     qx;
	logic                                 last_k;
	logic                                 div_last;

	// per-component operand selection
	always_comb begin
		case (k_q)
			2'd0: begin
				e10_sel = job_q.e10x;
				e20_sel = job_q.e20x;
			end
			2'd1: begin
				e10_sel = job_q.e10y;
				e20_sel = job_q.e20y;
			end
			default: begin
				e10_sel = job_q.e10z;
				e20_sel = job_q.e20z;
			end
		endcase
	end

	assign last_k   = (k_q == 2'd2);
	assign da       = job_q.d20u * job_q.d10v;
	assign db       = job_q.d20v * job_q.d10u;
	assign det      = (2*ttg_pkg::UVD_W+1)'(da) - (2*ttg_pkg::UVD_W+1)'(db);
	assign pa       = e20_sel * job_q.d10v;
	assign pb       = e10_sel * job_q.d20v;
	assign t_raw    = ttg_pkg::T_W'(pa) - ttg_pkg::T_W'(pb);
	assign t_dir    = flip_q ? -t_raw : t_raw;
	assign t_abs    = t_dir[ttg_pkg::T_W-1] ? ttg_pkg::MAG_W'(-t_dir) : ttg_pkg::MAG_W'(t_dir);
	assign sh       = ttg_pkg::NV_W'(mag_q[k_q]) << cnt_q;
	assign sqp      = m_q[k_q] * m_q[k_q];
	assign trial    = {1'b0, r_q} + {1'b0, bit_q};
	assign len      = r_q[ttg_pkg::RT_W-1:0];
	assign num      = (ttg_pkg::N_W'(m_q[k_q]) << ttg_pkg::UNIT_FRAC) + ttg_pkg::N_W'(len >> 1);
	assign rem2     = {rem_q[ttg_pkg::R_W-2:0], nlo_q[ttg_pkg::Q_W-1]};
	assign ge       = (rem2 >= ttg_pkg::R_W'(len));
	assign q_fin    = {q_q[ttg_pkg::Q_W-2:0], ge};
	assign qx       = ttg_pkg::TAN_W'(q_fin);
	assign div_last = (dcnt_q == ttg_pkg::DC_W'(ttg_pkg::Q_W - 1));

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		tan.valid = 1'b0;
		case (state_q)
			ttg_pkg::ST_IDLE: begin
				if (!qstat.empty) begin
					pop     = 1'b1;
					state_d = ttg_pkg::ST_DET;
				end
			end
			ttg_pkg::ST_DET: state_d = ttg_pkg::ST_TAN;
			ttg_pkg::ST_TAN: begin
				if (last_k) begin
					state_d = ((or_q | t_abs) == '0) ? ttg_pkg::ST_OUT : ttg_pkg::ST_LZ;
				end
			end
			ttg_pkg::ST_LZ: begin
				if (nv_q[ttg_pkg::NV_W-1]) begin
					state_d = ttg_pkg::ST_SHIFT;
				end
			end
			ttg_pkg::ST_SHIFT: begin
				if (last_k) begin
					state_d = ttg_pkg::ST_SQ;
				end
			end
			ttg_pkg::ST_SQ: begin
				if (last_k) begin
					state_d = ttg_pkg::ST_SQRT;
				end
			end
			ttg_pkg::ST_SQRT: begin
				if (bit_q[0]) begin
					state_d = ttg_pkg::ST_DINIT;
				end
			end
			ttg_pkg::ST_DINIT: state_d = ttg_pkg::ST_DIV;
			ttg_pkg::ST_DIV: begin
				if (div_last) begin
					state_d = last_k ? ttg_pkg::ST_OUT : ttg_pkg::ST_DINIT;
				end
			end
			ttg_pkg::ST_OUT: begin
				tan.valid = 1'b1;
				if (tan.ready && beat_q == 2'd2) begin
					state_d = ttg_pkg::ST_IDLE;
				end
			end
			default: state_d = ttg_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ttg_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_q <= 2'd0;
		end else if (state_q == ttg_pkg::ST_OUT && tan.ready) begin
			beat_q <= (beat_q == 2'd2) ? 2'd0 : beat_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ttg_pkg::ST_IDLE: begin
				job_q   <= head;
				degen_q <= 1'b0;
				k_q     <= 2'd0;
				or_q    <= '0;
				cnt_q   <= '0;
			end
			ttg_pkg::ST_DET: begin
				flip_q <= det[2*ttg_pkg::UVD_W];
			end
			ttg_pkg::ST_TAN: begin
				mag_q[k_q] <= t_abs;
				neg_q[k_q] <= t_dir[ttg_pkg::T_W-1];
				or_q       <= or_q | t_abs;
				nv_q       <= ttg_pkg::NV_W'(or_q | t_abs);
				k_q        <= last_k ? 2'd0 : k_q + 2'd1;
				if (last_k && (or_q | t_abs) == '0) begin
					degen_q   <= 1'b1;
					comp_q[0] <= '0;
					comp_q[1] <= '0;
					comp_q[2] <= '0;
				end
			end
			ttg_pkg::ST_LZ: begin
				if (!nv_q[ttg_pkg::NV_W-1]) begin
					if (nv_q[ttg_pkg::NV_W-1 -: 4] == 4'd0) begin
						nv_q  <= nv_q << 4;
						cnt_q <= cnt_q + ttg_pkg::CNT_W'(4);
					end else begin
						nv_q  <= nv_q << 1;
						cnt_q <= cnt_q + ttg_pkg::CNT_W'(1);
					end
				end
			end
			ttg_pkg::ST_SHIFT: begin
				m_q[k_q] <= sh[ttg_pkg::NV_W-1 -: ttg_pkg::NORM_BITS];
				k_q      <= last_k ? 2'd0 : k_q + 2'd1;
				sq_q     <= '0;
			end
			ttg_pkg::ST_SQ: begin
				sq_q <= sq_q + ttg_pkg::SQ_W'(sqp);
				k_q  <= last_k ? 2'd0 : k_q + 2'd1;
				if (last_k) begin
					x_q   <= sq_q + ttg_pkg::SQ_W'(sqp);
					r_q   <= '0;
					bit_q <= ttg_pkg::SQ_W'(1) << (2 * ttg_pkg::NORM_BITS);
				end
			end
			ttg_pkg::ST_SQRT: begin
				if ({1'b0, x_q} >= trial) begin
					x_q <= x_q - trial[ttg_pkg::SQ_W-1:0];
					r_q <= (r_q >> 1) + bit_q;
				end else begin
					r_q <= r_q >> 1;
				end
				bit_q <= bit_q >> 2;
			end
			ttg_pkg::ST_DINIT: begin
				rem_q  <= ttg_pkg::R_W'(num >> ttg_pkg::Q_W);
				nlo_q  <= num[ttg_pkg::Q_W-1:0];
				q_q    <= '0;
				dcnt_q <= '0;
			end
			ttg_pkg::ST_DIV: begin
				rem_q  <= ge ? rem2 - ttg_pkg::R_W'(len) : rem2;
				q_q    <= q_fin;
				nlo_q  <= nlo_q << 1;
				dcnt_q <= dcnt_q + 1'b1;
				if (div_last) begin
					comp_q[k_q] <= neg_q[k_q] ? -qx : qx;
					k_q         <= last_k ? 2'd0 : k_q + 2'd1;
				end
			end
			default: begin
			end
		endcase
	end

	assign tan.tan_x            = comp_q[0];
	assign tan.tan_y            = comp_q[1];
	assign tan.tan_z            = comp_q[2];
	assign tan.degenerate       = degen_q;
	assign tan.last_of_triangle = (beat_q == 2'd2);

`ifndef SYNTHESIS
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> state_q == ttg_pkg::ST_IDLE && !qstat.empty)
		else $error("pop outside idle");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		tan.valid && tan.degenerate |-> tan.tan_x == '0 && tan.tan_y == '0 && tan.tan_z == '0)
		else $error("degenerate tangent not zero");
	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		tan.valid && tan.ready && tan.last_of_triangle |=> state_q == ttg_pkg::ST_IDLE)
		else $error("triangle did not end after third beat");
	a_beat_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ttg_pkg::ST_OUT |-> beat_q == 2'd0)
		else $error("beat count stale outside output");
`endif

endmodule

// File: rtl/triangle_tangent_generator.sv
// triangle_tangent_generator: top level, front intake + job queue + tangent sequencer.
// Depends on ttg_pkg, ttg_if, ttg_front, ttg_fifo, ttg_back.
//
// Channel  Dir  Beat contents
// vtx      in   pos_x/y/z (Q16.16), tex_u/v (Q2.14), last_in_mesh
// tan      out  tan_x/y/z (Q2.14), degenerate, last_of_triangle
//
// The front takes the first two corners whenever offered. A third corner pushes a job of
// edge and UV differences into a two-deep queue; the front keeps taking vertices
// while the queue has room. The back spends most of its time on each triangle in the
// 31-step square root and three 15-step divides that share one datapath, then offers
// three result beats held in registers, and pops the next job only when idle again.
// Reset (arst_n low) clears the corner count, queue pointers and sequencer state.
// A stall on tan holds the back; the queue then fills and vtx deasserts ready
// only when a third corner arrives with no room.
module triangle_tangent_generator (
	input  logic       clk,
	input  logic       arst_n,
	ttg_vtx_if.sink    vtx,
	ttg_tan_if.source  tan
);

	ttg_pkg::q_push_t qpush;
	ttg_pkg::q_stat_t qstat;
	ttg_pkg::job_t    head;
	logic             pop;

	// intake and corner hold
	ttg_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.vtx    (vtx),
		.qstat  (qstat),
		.qpush  (qpush)
	);

	// decouples intake from the long tangent sequence
	ttg_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.qpush  (qpush),
		.pop    (pop),
		.qstat  (qstat),
		.head   (head)
	);

	// products, normalize, rsqrt via sqrt + divide, three beats out
	ttg_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.qstat  (qstat),
		.head   (head),
		.pop    (pop),
		.tan    (tan)
	);

endmodule
